@@ src/text_bounding_box_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Text bounding box unit: assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_BOUNDING_BOX_UNIT_ASSERT_SVH
`define TEXT_BOUNDING_BOX_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define TBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked in reset as well
`define TBB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TBB_ASSERT(label, prop, msg)
`define TBB_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ src/tbb_pkg.sv @@
// ----------------------------------------------------------------------------
// Text bounding box package
// Transaction types, register indexes and character codes.
// ----------------------------------------------------------------------------
package tbb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_CODE   = 3'd0,
        CFG_LAST_CODE    = 3'd1,
        CFG_LINE_ADVANCE = 3'd2,
        CFG_SCREEN_WIDTH = 3'd3,
        CFG_WRAP_ENABLE  = 3'd4
    } t_cfg_idx;

    localparam logic [7:0]  RST_FIRST_CODE   = 8'd32;
    localparam logic [7:0]  RST_LAST_CODE    = 8'd126;
    localparam logic [7:0]  RST_LINE_ADVANCE = 8'd8;
    localparam logic [14:0] RST_SCREEN_WIDTH = 15'd320;
    localparam logic        RST_WRAP_ENABLE  = 1'b1;

    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // empty box: least above most
    localparam logic signed [15:0] BOX_LEAST_INIT = 16'sh7FFF;
    localparam logic signed [15:0] BOX_MOST_INIT  = -16'sd1;

    typedef struct packed {
        logic [7:0]         char_code;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  glyph_x_offset;
        logic signed [7:0]  glyph_y_offset;
        logic [7:0]         glyph_x_advance;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic               first_item;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
    } t_out_item;

endpackage

@@ src/tbb_in_if.sv @@
// ----------------------------------------------------------------------------
// Text bounding box input channel
// Valid/ready channel carrying one character with its glyph metrics.
// ----------------------------------------------------------------------------
interface tbb_in_if import tbb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/tbb_out_if.sv @@
// ----------------------------------------------------------------------------
// Text bounding box output channel
// Valid/ready channel carrying one bounding box result.
// ----------------------------------------------------------------------------
interface tbb_out_if import tbb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/text_bounding_box_unit.sv @@
// ----------------------------------------------------------------------------
// Text bounding box unit
// Pen tracking and min/max box of a string set in a proportional font.
// ----------------------------------------------------------------------------
// Takes one character per transaction on i_in and emits one box on o_out for
// every character marked last_item. Throughput is one character per clock
// while no last_item character waits on a full output register; a character
// is held in an input register, where the pen and box registers are updated
// by a single pass of adds and compares, and a last_item character's box is
// registered in the output register as it leaves. The pen/box update loop
// sets that rate. Only a last_item character waits for a stalled output
// register; other characters keep flowing while a finished box waits to be
// taken. Configuration writes on i_cfg_* take effect at the next edge and are meant for idle periods.
// ----------------------------------------------------------------------------
`include "text_bounding_box_unit_assert.svh"

module text_bounding_box_unit import tbb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tbb_in_if.sink                i_in,
    tbb_out_if.source             o_out
);

    // configuration
    logic [7:0]  r_first_code;
    logic [7:0]  r_last_code;
    logic [7:0]  r_line_advance;
    logic [14:0] r_screen_width;
    logic        r_wrap_enable;

    // string state
    logic signed [15:0] r_pen_x, r_pen_y, r_origin_x, r_origin_y;
    logic signed [15:0] r_least_x, r_least_y, r_most_x, r_most_y;
    logic               r_terminated;

    // input register and output register
    t_in_item  r_s1;
    logic      r_s1_valid;
    t_out_item r_out;
    logic      r_out_valid;

    // handshake
    logic in_fire, out_free, s1_fire;

    assign out_free   = !r_out_valid || o_out.ready;
    // only a box-producing character needs room in the output register
    assign s1_fire    = r_s1_valid && (!r_s1.last_item || out_free);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------
    // Character processing on the held item
    // ------------------------------------------------------------------
    logic signed [15:0] cur_pen_x, cur_pen_y, cur_origin_x, cur_origin_y;
    logic signed [15:0] cur_least_x, cur_least_y, cur_most_x, cur_most_y;
    logic               cur_term;

    logic is_nul, is_lf, is_cr, in_range, live, glyph;
    logic signed [17:0] wrap_sum;
    logic               wrap_hit, glyph_wrap, new_line;
    logic signed [15:0] pen_y_nl, gx_pen, gy_pen;
    logic signed [15:0] x_off16, y_off16, x1, y1, x2, y2;

    logic signed [15:0] n_pen_x, n_pen_y;
    logic signed [15:0] n_least_x, n_least_y, n_most_x, n_most_y;
    logic               n_terminated;
    t_out_item          n_out;

    always_comb begin
        // a first item restarts the string before the character is handled
        if (r_s1.first_item) begin
            cur_pen_x    = r_s1.start_x;
            cur_pen_y    = r_s1.start_y;
            cur_origin_x = r_s1.start_x;
            cur_origin_y = r_s1.start_y;
            cur_least_x  = BOX_LEAST_INIT;
            cur_least_y  = BOX_LEAST_INIT;
            cur_most_x   = BOX_MOST_INIT;
            cur_most_y   = BOX_MOST_INIT;
            cur_term     = 1'b0;
        end else begin
            cur_pen_x    = r_pen_x;
            cur_pen_y    = r_pen_y;
            cur_origin_x = r_origin_x;
            cur_origin_y = r_origin_y;
            cur_least_x  = r_least_x;
            cur_least_y  = r_least_y;
            cur_most_x   = r_most_x;
            cur_most_y   = r_most_y;
            cur_term     = r_terminated;
        end

        is_nul   = (r_s1.char_code == CHAR_NUL);
        is_lf    = (r_s1.char_code == CHAR_LF);
        is_cr    = (r_s1.char_code == CHAR_CR);
        in_range = (r_s1.char_code >= r_first_code) && (r_s1.char_code <= r_last_code);
        live     = !cur_term && !is_nul;
        glyph    = live && !is_lf && !is_cr && in_range;

        // wrap test in 18 bits so it never wraps
        wrap_sum = {{2{cur_pen_x[15]}}, cur_pen_x}
                 + {{10{r_s1.glyph_x_offset[7]}}, r_s1.glyph_x_offset}
                 + {10'd0, r_s1.glyph_width};
        wrap_hit   = r_wrap_enable && (wrap_sum > $signed({3'd0, r_screen_width}));
        glyph_wrap = glyph && wrap_hit;
        new_line   = (live && is_lf) || glyph_wrap;

        pen_y_nl = cur_pen_y + $signed({8'd0, r_line_advance});
        gx_pen   = glyph_wrap ? 16'sd0 : cur_pen_x;
        gy_pen   = glyph_wrap ? pen_y_nl : cur_pen_y;

        x_off16 = {{8{r_s1.glyph_x_offset[7]}}, r_s1.glyph_x_offset};
        y_off16 = {{8{r_s1.glyph_y_offset[7]}}, r_s1.glyph_y_offset};
        x1 = gx_pen + x_off16;
        y1 = gy_pen + y_off16;
        // zero-size glyphs give an edge one left of / above the origin
        x2 = x1 + $signed({8'd0, r_s1.glyph_width}) - 16'sd1;
        y2 = y1 + $signed({8'd0, r_s1.glyph_height}) - 16'sd1;

        n_least_x = (glyph && (x1 < cur_least_x)) ? x1 : cur_least_x;
        n_least_y = (glyph && (y1 < cur_least_y)) ? y1 : cur_least_y;
        n_most_x  = (glyph && (x2 > cur_most_x)) ? x2 : cur_most_x;
        n_most_y  = (glyph && (y2 > cur_most_y)) ? y2 : cur_most_y;

        if (glyph) begin
            n_pen_x = gx_pen + $signed({8'd0, r_s1.glyph_x_advance});
        end else if (new_line) begin
            n_pen_x = 16'sd0;
        end else begin
            n_pen_x = cur_pen_x;
        end
        n_pen_y      = new_line ? pen_y_nl : cur_pen_y;
        n_terminated = cur_term || is_nul;

        // empty axis reports the origin with zero size
        if (n_most_x >= n_least_x) begin
            n_out.box_x     = n_least_x;
            n_out.box_width = n_most_x - n_least_x + 16'sd1;
        end else begin
            n_out.box_x     = cur_origin_x;
            n_out.box_width = 16'd0;
        end
        if (n_most_y >= n_least_y) begin
            n_out.box_y      = n_least_y;
            n_out.box_height = n_most_y - n_least_y + 16'sd1;
        end else begin
            n_out.box_y      = cur_origin_y;
            n_out.box_height = 16'd0;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code   <= RST_FIRST_CODE;
            r_last_code    <= RST_LAST_CODE;
            r_line_advance <= RST_LINE_ADVANCE;
            r_screen_width <= RST_SCREEN_WIDTH;
            r_wrap_enable  <= RST_WRAP_ENABLE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_CODE:   r_first_code   <= i_cfg_data[7:0];
                CFG_LAST_CODE:    r_last_code    <= i_cfg_data[7:0];
                CFG_LINE_ADVANCE: r_line_advance <= i_cfg_data[7:0];
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[14:0];
                CFG_WRAP_ENABLE:  r_wrap_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline and string state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pen_x      <= 16'sd0;
            r_pen_y      <= 16'sd0;
            r_origin_x   <= 16'sd0;
            r_origin_y   <= 16'sd0;
            r_least_x    <= BOX_LEAST_INIT;
            r_least_y    <= BOX_LEAST_INIT;
            r_most_x     <= BOX_MOST_INIT;
            r_most_y     <= BOX_MOST_INIT;
            r_terminated <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_pen_x      <= n_pen_x;
                r_pen_y      <= n_pen_y;
                r_origin_x   <= cur_origin_x;
                r_origin_y   <= cur_origin_y;
                r_least_x    <= n_least_x;
                r_least_y    <= n_least_y;
                r_most_x     <= n_most_x;
                r_most_y     <= n_most_y;
                r_terminated <= n_terminated;
            end

            if (s1_fire && r_s1.last_item) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in.data;
        end
        if (s1_fire && r_s1.last_item) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TBB_ASSERT_RST(a_rst_out_empty, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `TBB_ASSERT(a_stall_holds_item, !i_in.ready |-> r_s1_valid, "input stalled with empty stage")
    `TBB_ASSERT(a_item_kept, r_s1_valid && !s1_fire |=> r_s1_valid, "held character dropped")
    `TBB_ASSERT(a_last_gives_box, s1_fire && r_s1.last_item |=> r_out_valid, "box not produced")
    `TBB_ASSERT(a_nul_terminates, s1_fire && (r_s1.char_code == CHAR_NUL) |=> r_terminated,
        "terminator not recorded")

endmodule

@@ verif/text_bounding_box_unit_checker.sv @@
// ----------------------------------------------------------------------------
// Text bounding box unit: scoreboard
// Watches the config port and both channels, tracks pen and box per string,
// and compares every emitted box against the oldest predicted one.
// ----------------------------------------------------------------------------
module text_bounding_box_unit_checker import tbb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tbb_in_if                     i_chars,
    tbb_out_if                    i_boxes,
    output int                    o_fail_count,
    output int                    o_boxes_pending
);

    localparam int REPORT_LIMIT = 10;

    // font and layout settings as last written
    logic [7:0]  font_lo, font_hi, line_step;
    logic [14:0] wrap_limit;
    logic        wrap_on;

    // pen, string origin and running extent
    logic signed [15:0] cur_x, cur_y, home_x, home_y;
    logic signed [15:0] left_edge, top_edge, right_edge, bottom_edge;
    logic               string_ended;

    t_out_item boxes_due[$];

    task automatic line_feed();
        cur_x = '0;
        cur_y = cur_y + $signed({8'd0, line_step});
    endtask

    // one character transaction; queues a box when it closes the string
    task automatic track_char(input t_in_item t);
        logic signed [15:0] x1, y1, x2, y2;
        int                 reach;
        t_out_item          box;
        if (t.first_item) begin
            cur_x        = t.start_x;
            cur_y        = t.start_y;
            home_x       = t.start_x;
            home_y       = t.start_y;
            left_edge    = BOX_LEAST_INIT;
            top_edge     = BOX_LEAST_INIT;
            right_edge   = BOX_MOST_INIT;
            bottom_edge  = BOX_MOST_INIT;
            string_ended = 1'b0;
        end
        if (!string_ended) begin
            if (t.char_code == CHAR_NUL) begin
                string_ended = 1'b1;
            end else if (t.char_code == CHAR_LF) begin
                line_feed();
            end else if (t.char_code != CHAR_CR && t.char_code >= font_lo &&
                         t.char_code <= font_hi) begin
                // wrap test is done at full precision
                reach = int'(cur_x) + int'($signed(t.glyph_x_offset)) +
                        int'(t.glyph_width);
                if (wrap_on && reach > int'(wrap_limit))
                    line_feed();
                x1 = cur_x + $signed(t.glyph_x_offset);
                y1 = cur_y + $signed(t.glyph_y_offset);
                x2 = x1 + $signed({8'd0, t.glyph_width}) - 16'sd1;
                y2 = y1 + $signed({8'd0, t.glyph_height}) - 16'sd1;
                if (x1 < left_edge)   left_edge   = x1;
                if (y1 < top_edge)    top_edge    = y1;
                if (x2 > right_edge)  right_edge  = x2;
                if (y2 > bottom_edge) bottom_edge = y2;
                cur_x = cur_x + $signed({8'd0, t.glyph_x_advance});
            end
        end
        if (t.last_item) begin
            if (right_edge >= left_edge) begin
                box.box_x     = left_edge;
                box.box_width = right_edge - left_edge + 16'sd1;
            end else begin
                box.box_x     = home_x;
                box.box_width = '0;
            end
            if (bottom_edge >= top_edge) begin
                box.box_y      = top_edge;
                box.box_height = bottom_edge - top_edge + 16'sd1;
            end else begin
                box.box_y      = home_y;
                box.box_height = '0;
            end
            boxes_due.push_back(box);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_box;
        t_out_item got_box;
        if (!i_rst_n) begin
            o_fail_count = 0;
            font_lo      = RST_FIRST_CODE;
            font_hi      = RST_LAST_CODE;
            line_step    = RST_LINE_ADVANCE;
            wrap_limit   = RST_SCREEN_WIDTH;
            wrap_on      = RST_WRAP_ENABLE;
            cur_x        = '0;
            cur_y        = '0;
            home_x       = '0;
            home_y       = '0;
            left_edge    = BOX_LEAST_INIT;
            top_edge     = BOX_LEAST_INIT;
            right_edge   = BOX_MOST_INIT;
            bottom_edge  = BOX_MOST_INIT;
            string_ended = 1'b0;
            boxes_due.delete();
        end else begin
            if (i_boxes.valid && i_boxes.ready) begin
                got_box = i_boxes.data;
                if (boxes_due.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("unexpected box x=%0d y=%0d w=%0d h=%0d",
                                 got_box.box_x, got_box.box_y,
                                 got_box.box_width, got_box.box_height);
                    o_fail_count++;
                end else begin
                    exp_box = boxes_due.pop_front();
                    if (got_box.box_x !== exp_box.box_x ||
                        got_box.box_y !== exp_box.box_y ||
                        got_box.box_width !== exp_box.box_width ||
                        got_box.box_height !== exp_box.box_height) begin
                        if (o_fail_count < REPORT_LIMIT)
                            $display({"box mismatch: expected x=%0d y=%0d w=%0d h=%0d,",
                                      " got x=%0d y=%0d w=%0d h=%0d"},
                                     exp_box.box_x, exp_box.box_y,
                                     exp_box.box_width, exp_box.box_height,
                                     got_box.box_x, got_box.box_y,
                                     got_box.box_width, got_box.box_height);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIRST_CODE:   font_lo    = i_cfg_data[7:0];
                    CFG_LAST_CODE:    font_hi    = i_cfg_data[7:0];
                    CFG_LINE_ADVANCE: line_step  = i_cfg_data[7:0];
                    CFG_SCREEN_WIDTH: wrap_limit = i_cfg_data[14:0];
                    CFG_WRAP_ENABLE:  wrap_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_chars.valid && i_chars.ready)
                track_char(i_chars.data);
        end
        o_boxes_pending = boxes_due.size();
    end

endmodule

@@ verif/text_bounding_box_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Text bounding box unit: testbench top
// Drives strings of glyph transactions through several font settings and
// flow-control patterns; the scoreboard beside the block checks every box.
// ----------------------------------------------------------------------------
module text_bounding_box_unit_tb;
    import tbb_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;
    // settling time after the last predicted box covers characters
    // still in flight that produce no box
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tbb_in_if  chars();
    tbb_out_if boxes();

    int          fail_count;
    int          boxes_pending;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          cycle_count   = 0;

    // font range as last programmed; steers the character picker
    logic [7:0] font_lo = RST_FIRST_CODE;
    logic [7:0] font_hi = RST_LAST_CODE;

    text_bounding_box_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (chars),
        .o_out      (boxes)
    );

    text_bounding_box_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_chars         (chars),
        .i_boxes         (boxes),
        .o_fail_count    (fail_count),
        .o_boxes_pending (boxes_pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL text_bounding_box_unit");
            $finish;
        end
    end

    // Box receiver. Random stalls per stall_pct; a hold request turns into
    // a long run of back-pressure counted here, so the block backs up.
    initial begin
        boxes.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                boxes.ready <= 1'b0;
            end else begin
                boxes.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one transaction and return at the falling edge after acceptance.
    // valid stays high so a back-to-back item never drops it in between.
    task automatic send_char(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            chars.valid <= 1'b0;
            @(negedge i_clk);
        end
        chars.valid <= 1'b1;
        chars.data  <= item;
        @(posedge i_clk);
        while (!chars.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] code, w, h,
                            input logic signed [7:0] xo, yo,
                            input logic [7:0] xa,
                            input logic signed [15:0] sx, sy,
                            input bit first, last);
        t_in_item g;
        g.char_code       = code;
        g.glyph_width     = w;
        g.glyph_height    = h;
        g.glyph_x_offset  = xo;
        g.glyph_y_offset  = yo;
        g.glyph_x_advance = xa;
        g.start_x         = sx;
        g.start_y         = sy;
        g.first_item      = first;
        g.last_item       = last;
        send_char(g);
    endtask

    // Mostly font-like metrics near the origin; now and then anything at all
    // so every bit of every field toggles.
    function automatic t_in_item random_glyph(input logic [7:0] code);
        t_in_item g;
        g = '0;
        g.char_code = code;
        if ($urandom_range(7) == 0) begin
            g.glyph_width     = 8'($urandom);
            g.glyph_height    = 8'($urandom);
            g.glyph_x_offset  = 8'($urandom);
            g.glyph_y_offset  = 8'($urandom);
            g.glyph_x_advance = 8'($urandom);
        end else begin
            g.glyph_width     = 8'($urandom_range(16, 0));
            g.glyph_height    = 8'($urandom_range(16, 0));
            g.glyph_x_offset  = 8'($urandom_range(6, 0)) - 8'd3;
            g.glyph_y_offset  = 8'($urandom_range(12, 0)) - 8'd10;
            g.glyph_x_advance = g.glyph_width + 8'($urandom_range(2, 0));
        end
        if ($urandom_range(4) == 0) begin
            g.start_x = 16'($urandom);
            g.start_y = 16'($urandom);
        end else begin
            g.start_x = 16'($urandom_range(300, 0));
            g.start_y = 16'($urandom_range(200, 0));
        end
        return g;
    endfunction

    // newline, return, terminator and stray bytes mixed into font codes
    function automatic logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6)
            return CHAR_LF;
        if (r < 9)
            return CHAR_CR;
        if (r < 11)
            return CHAR_NUL;
        if (r < 18 || font_lo > font_hi)
            return 8'($urandom);
        return 8'($urandom_range(font_hi, font_lo));
    endfunction

    // well-formed string: first flag on the head, last flag on the tail
    task automatic send_string(input int len);
        t_in_item g;
        for (int k = 0; k < len; k++) begin
            g            = random_glyph(pick_code());
            g.first_item = (k == 0);
            g.last_item  = (k == len - 1);
            send_char(g);
        end
    endtask

    // mostly strings, some loose transactions with random flags
    task automatic random_text(input int count);
        int sent;
        int len;
        t_in_item g;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                g            = random_glyph(8'($urandom));
                g.first_item = 1'($urandom);
                g.last_item  = 1'($urandom);
                send_char(g);
                sent++;
            end else begin
                len = $urandom_range(10, 1);
                send_string(len);
                sent += len;
            end
        end
    endtask

    // stop offering, wait for every predicted box, then let the pipe empty
    task automatic settle();
        chars.valid <= 1'b0;
        @(negedge i_clk);
        while (boxes_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic program_font(input logic [7:0] lo, hi, step,
                                input logic [14:0] width,
                                input logic wrap);
        put_reg(CFG_FIRST_CODE, CFG_DATA_W'(lo));
        put_reg(CFG_LAST_CODE, CFG_DATA_W'(hi));
        put_reg(CFG_LINE_ADVANCE, CFG_DATA_W'(step));
        put_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(width));
        put_reg(CFG_WRAP_ENABLE, CFG_DATA_W'(wrap));
        cfg_we <= 1'b0;
        @(negedge i_clk);
        font_lo = lo;
        font_hi = hi;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        chars.valid = 1'b0;
        chars.data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed, reset font settings, no idling ----
        // plain two-glyph string
        put_char("H", 6, 8, 0, -7, 7, 10, 20, 1, 0);
        put_char("i", 2, 8, 1, -7, 4, 0, 0, 0, 1);
        // carriage return only: empty box at the start position
        put_char(CHAR_CR, 5, 5, 1, 1, 5, 123, -45, 1, 1);
        // newline between glyphs
        put_char("A", 5, 7, 0, -6, 6, 100, 50, 1, 0);
        put_char(CHAR_LF, 9, 9, 0, 0, 9, 0, 0, 0, 0);
        put_char("B", 5, 7, 0, -6, 6, 0, 0, 0, 1);
        // terminator first: the rest of the string is ignored
        put_char(CHAR_NUL, 4, 4, 0, 0, 4, -7, 9, 1, 0);
        put_char("A", 5, 7, 0, -6, 6, 0, 0, 0, 1);
        // codes just outside the font range and far outside
        put_char(8'd31, 5, 5, 0, 0, 5, 1, 2, 1, 0);
        put_char(8'd127, 5, 5, 0, 0, 5, 0, 0, 0, 0);
        put_char(8'd200, 5, 5, 0, 0, 5, 0, 0, 0, 1);
        // zero-size glyph: right edge lands left of the left edge
        put_char("a", 0, 0, 0, 0, 0, 40, 40, 1, 1);
        // largest glyphs at the top of the coordinate range: wrap, y wraps
        put_char("W", 255, 255, 127, 127, 255, 32767, 32767, 1, 0);
        put_char("W", 255, 255, -128, -128, 255, 0, 0, 0, 1);
        // most negative start with most negative offsets
        put_char(8'd126, 255, 255, -128, -128, 0, -32768, -32768, 1, 1);
        // no first flag: string continues from where the last one stopped
        put_char("Z", 3, 3, 0, 0, 4, 0, 0, 0, 1);
        // font range edges
        put_char(8'd32, 4, 6, 0, 0, 4, 0, 0, 1, 0);
        put_char(8'd126, 4, 6, 0, 0, 4, 0, 0, 0, 1);
        // glyph ending exactly on the screen width, then one past it
        put_char("M", 10, 8, 0, 0, 10, 310, 0, 1, 0);
        put_char("M", 10, 8, 0, 0, 10, 0, 0, 0, 1);
        random_text(60);
        settle();

        // ---- whole byte range as font, widest screen; sender idles ----
        program_font(8'd0, 8'd255, 8'd255, 15'd32767, 1'b1);
        send_idle_pct = 86;
        stall_pct     = 0;
        random_text(90);
        settle();

        // ---- empty font range, zero width, wrap off; receiver stalls ----
        program_font(8'd255, 8'd0, 8'd0, 15'd0, 1'b0);
        send_idle_pct = 0;
        stall_pct     = 86;
        random_text(90);
        settle();

        // ---- narrow screen with wrap; both sides idle ----
        program_font(8'd32, 8'd126, 8'd8, 15'd64, 1'b1);
        send_idle_pct = 27;
        stall_pct     = 27;
        random_text(100);
        settle();

        // ---- back-pressure: receiver holds off while one-glyph strings
        //      keep coming, so the box register fills and input stalls ----
        program_font(8'd48, 8'd90, 8'd12, 15'd24, 1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        repeat (40) send_string(1);
        random_text(40);
        settle();

        // ---- wide font, wrap off; no idling ----
        program_font(8'd1, 8'd254, 8'd16, 15'd100, 1'b0);
        random_text(80);
        settle();

        if (fail_count == 0)
            $display("PASS text_bounding_box_unit");
        else
            $display("FAIL text_bounding_box_unit");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/tbb_pkg.sv
src/tbb_in_if.sv
src/tbb_out_if.sv
src/text_bounding_box_unit.sv
verif/text_bounding_box_unit_checker.sv
verif/text_bounding_box_unit_tb.sv
